// ----- sv/i2cmts_pkg.sv -----
`default_nettype none
package i2cmts_pkg;

   // buffer geometry
   localparam int BUFFER_DEPTH_DEFAULT = 16;
   localparam int INDEX_W = 4;
   localparam int BYTE_W = 8;
   localparam int LEN_W = 4;
   localparam int CSR_INDEX_W = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECEIVE_LENGTH = 2'd1;

   // bus action codes
   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_SEND = 3'd1;
   localparam logic [2:0] ACT_STOP = 3'd2;
   localparam logic [2:0] ACT_RSTART = 3'd3;
   localparam logic [2:0] ACT_RECV_ACK = 3'd4;
   localparam logic [2:0] ACT_RECV_LAST = 3'd5;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // address byte masks
   localparam logic [BYTE_W-1:0] ADDR_WRITE_MASK = 8'hFE;
   localparam logic [BYTE_W-1:0] ADDR_READ_BIT = 8'h01;
   localparam logic [BYTE_W-1:0] FULL_MASK = 8'hFF;

   // receive data lands from this entry on
   localparam logic [INDEX_W-1:0] RX_BASE = 4'd3;

   typedef struct packed {
      logic               operation;
      logic [INDEX_W-1:0] load_index;
      logic [BYTE_W-1:0]  load_value;
      logic               start_pending;
      logic               nack_seen;
      logic [BYTE_W-1:0]  received_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         bus_action;
      logic [BYTE_W-1:0]  send_byte;
      logic               store_valid;
      logic [INDEX_W-1:0] store_index;
      logic               transfer_error;
      logic               read_done;
      logic               write_done;
      logic [2:0]         phase;
   } rsp_word_type;

endpackage
`default_nettype wire

// ----- sv/i2cmts_ram.sv -----
`default_nettype none
module i2cmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- sv/i2c_master_transfer_sequencer.sv -----
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_word  (load or bus event)
// rsp       out        rsp_valid / rsp_ready  rsp_word  (one result per request)
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// one request per cycle unless the pipe stalls; results pass the registered ram
// read, then the output register. sequencing state updates in the accept cycle,
// so back-to-back events never wait on a read. reset clears phase, position,
// send length and valids, sets receive length to one; the buffer holds garbage
// until loaded. a stalled result still lets one more request in.
module i2c_master_transfer_sequencer
   #(
   parameter int BUFFER_DEPTH = i2cmts_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire i2cmts_pkg::req_word_type             req_word,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output i2cmts_pkg::rsp_word_type                  rsp_word,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [i2cmts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [i2cmts_pkg::LEN_W-1:0]         csr_data
);
   import i2cmts_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SENDING,
      PH_STOPPING,
      PH_RSTART,
      PH_READ_ADDR,
      PH_RECEIVING
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [INDEX_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]   send_len_ff, recv_len_ff;
   logic               read_bit_ff;

   // read stage and output stage
   logic               s1_valid_ff, s1_valid_in;
   rsp_word_type       s1_word_ff, s1_word_in;
   logic               s1_send_ff, s1_send_in;
   logic [BYTE_W-1:0]  s1_mask_ff, s1_mask_in;
   logic               s1_ok_ff, s1_ok_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_word_ff, out_word_in;

   logic               accept, advance;
   logic               wr_en, rd_en;
   logic [INDEX_W-1:0] wr_idx, rd_idx;
   logic [BYTE_W-1:0]  wr_data, rd_data;
   logic [LEN_W-1:0]   rl;
   logic [INDEX_W-1:0] tgt, pos_next;
   logic [LEN_W:0]     pos_plus;

   // handshake
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // receive length zero counts as one
   assign rl       = (recv_len_ff == '0) ? LEN_W'(1) : recv_len_ff;
   assign tgt      = pos_ff + RX_BASE;
   assign pos_next = pos_ff + INDEX_W'(1);
   assign pos_plus = {1'b0, pos_next} + (LEN_W+1)'(1);

   // sequencing decision in the accept cycle
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      s1_word_in = '0;
      s1_send_in = 1'b0;
      s1_mask_in = FULL_MASK;
      s1_ok_in   = 1'b1;
      wr_en      = 1'b0;
      wr_idx     = req_word.load_index;
      wr_data    = req_word.load_value;
      rd_en      = 1'b0;
      rd_idx     = '0;
      if (req_word.operation == OP_LOAD) begin
         wr_en = 9'(req_word.load_index) < DEPTH_W;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (!req_word.start_pending) begin
                  s1_word_in.bus_action = ACT_SEND;
                  s1_send_in = 1'b1;
                  s1_mask_in = ADDR_WRITE_MASK;
                  rd_en      = 1'b1;
                  phase_in   = PH_SENDING;
                  pos_in     = INDEX_W'(1);
               end
            end
            PH_SENDING: begin
               if (req_word.nack_seen) begin
                  s1_word_in.bus_action = ACT_STOP;
                  s1_word_in.transfer_error = 1'b1;
                  phase_in = PH_STOPPING;
               end else if (pos_ff != '0 && pos_ff <= send_len_ff) begin
                  s1_word_in.bus_action = ACT_SEND;
                  s1_send_in = 1'b1;
                  s1_ok_in   = 9'(pos_ff) < DEPTH_W;
                  rd_en      = 1'b1;
                  rd_idx     = pos_ff;
                  pos_in     = pos_next;
               end else if (read_bit_ff) begin
                  s1_word_in.bus_action = ACT_RSTART;
                  phase_in = PH_RSTART;
               end else begin
                  s1_word_in.bus_action = ACT_STOP;
                  s1_word_in.write_done = 1'b1;
                  phase_in = PH_STOPPING;
               end
            end
            PH_STOPPING: begin
               phase_in = PH_IDLE;
            end
            PH_RSTART: begin
               s1_word_in.bus_action = ACT_SEND;
               s1_send_in = 1'b1;
               rd_en      = 1'b1;
               phase_in   = PH_READ_ADDR;
            end
            PH_READ_ADDR: begin
               if (req_word.nack_seen) begin
                  s1_word_in.bus_action = ACT_STOP;
                  s1_word_in.transfer_error = 1'b1;
                  phase_in = PH_STOPPING;
               end else begin
                  s1_word_in.bus_action = (rl == LEN_W'(1)) ? ACT_RECV_LAST : ACT_RECV_ACK;
                  pos_in   = '0;
                  phase_in = PH_RECEIVING;
               end
            end
            PH_RECEIVING: begin
               wr_idx  = tgt;
               wr_data = req_word.received_byte;
               if (9'(tgt) < DEPTH_W) begin
                  wr_en = 1'b1;
                  s1_word_in.store_valid = 1'b1;
                  s1_word_in.store_index = tgt;
               end
               pos_in = pos_next;
               if (pos_next == rl) begin
                  s1_word_in.bus_action = ACT_STOP;
                  s1_word_in.read_done = 1'b1;
                  phase_in = PH_STOPPING;
               end else begin
                  s1_word_in.bus_action =
                     (pos_plus == {1'b0, rl}) ? ACT_RECV_LAST : ACT_RECV_ACK;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      s1_word_in.phase = phase_in;
   end

   // pipeline valids
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // merge the buffer byte into the result
   always_comb begin
      out_word_in = s1_word_ff;
      out_word_in.send_byte = (s1_send_ff && s1_ok_ff) ? (rd_data & s1_mask_ff) : '0;
   end

   // state, lengths and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         send_len_ff  <= '0;
         recv_len_ff  <= LEN_W'(1);
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEND_LENGTH:    send_len_ff <= csr_data;
               CSR_RECEIVE_LENGTH: recv_len_ff <= csr_data;
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         s1_word_ff <= s1_word_in;
         s1_send_ff <= s1_send_in;
         s1_mask_ff <= s1_mask_in;
         s1_ok_ff   <= s1_ok_in;
      end
      // copy of the address read bit, follows every write of entry 0
      // (loads and received bytes that wrap onto it)
      if (accept && wr_en && wr_idx == '0) begin
         read_bit_ff <= (wr_data & ADDR_READ_BIT) != '0;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   // transfer buffer
   i2cmts_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (AW'(wr_idx)),
      .wr_data (wr_data),
      .rd_en   (accept && rd_en),
      .rd_addr (AW'(rd_idx)),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire
